### sv/tos_pkg.sv
// ----------------------------------------------------------------------------
// Topological order scheduler package
// Shared sizes, codes, sequencer states and the node table request/response.
// ----------------------------------------------------------------------------
package tos_pkg;

  localparam int MAX_NODES    = 32;
  localparam int KEY_BITS     = 64;
  localparam int SLOT_W       = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);
  localparam int KEY_FIELD_W  = 64;
  localparam int SLOT_FIELD_W = 5;
  localparam int STATUS_W     = 3;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_DUP     = 3'd2,
    STAT_UNKNOWN = 3'd3,
    STAT_EMPTY   = 3'd4,
    STAT_CYCLE   = 3'd5
  } status_t;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_RUN = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_RS_NEXT,
    ST_RS_PKEY,
    ST_RS_SCAN,
    ST_EM_SCAN,
    ST_REPORT
  } state_t;

  // Requests from the sequencer to the node table
  typedef struct packed {
    logic  wr_en;
    slot_t wr_slot;
    key_t  wr_key;
    key_t  wr_pred;
    slot_t key_rd_slot;
    slot_t pred_rd_slot;
    key_t  ref_key;
  } tbl_req_t;

  // Registered read data and the shared comparator results
  typedef struct packed {
    key_t rd_key;
    key_t rd_pred;
    logic key_eq;
    logic key_lt;
  } tbl_rsp_t;

  // Map a slot number onto the result field, dropping or padding upper bits
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(slot_t s);
    logic [63:0] w;
    w = 64'(s);
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

### sv/tos_node_table.sv
// ----------------------------------------------------------------------------
// Node table
// Key and predecessor key memories with registered reads, plus the single
// key comparator shared by the duplicate, resolve and minimum scans.
// ----------------------------------------------------------------------------
module tos_node_table (
  input  logic               clk,
  input  tos_pkg::tbl_req_t  req,
  output tos_pkg::tbl_rsp_t  rsp
);

  tos_pkg::key_t key_mem  [tos_pkg::MAX_NODES];
  tos_pkg::key_t pred_mem [tos_pkg::MAX_NODES];
  tos_pkg::key_t rd_key_r;
  tos_pkg::key_t rd_pred_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_slot]  <= req.wr_key;
      pred_mem[req.wr_slot] <= req.wr_pred;
    end
    rd_key_r  <= key_mem[req.key_rd_slot];
    rd_pred_r <= pred_mem[req.pred_rd_slot];
  end

  // Compare the key read last cycle against the reference key
  assign rsp.rd_key  = rd_key_r;
  assign rsp.rd_pred = rd_pred_r;
  assign rsp.key_eq  = (rd_key_r == req.ref_key);
  assign rsp.key_lt  = (rd_key_r < req.ref_key);

endmodule

### sv/topological_order_scheduler.sv
// ----------------------------------------------------------------------------
// Topological order scheduler
// Loads nodes with an optional single predecessor, then emits them in
// topological order, smallest key first among the ready nodes.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   operation, node_key, pred_key, has_pred
//  out_     output     out_valid/out_stall status, emitted_key, emitted_slot, last_result
//
//  An add item checks for a duplicate key: every stored key passes the shared
//  comparator once, one key a cycle, from the key memory's registered port.
//  A run item first resolves each node that has a predecessor with a scan for
//  its predecessor key, then handles each emitted node with one full scan of
//  the table for the minimum ready key, plus the result hand-off.
//  The block takes no item while it works on one. A stalled result port holds
//  the sequencer in its reporting state. Reset (rst_n low, synchronous) empties
//  the graph; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module topological_order_scheduler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [tos_pkg::KEY_FIELD_W-1:0]      in_node_key,
  input  logic [tos_pkg::KEY_FIELD_W-1:0]      in_pred_key,
  input  logic                                 in_has_pred,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tos_pkg::STATUS_W-1:0]         out_status,
  output logic [tos_pkg::KEY_FIELD_W-1:0]      out_emitted_key,
  output logic [tos_pkg::SLOT_FIELD_W-1:0]     out_emitted_slot,
  output logic                                 out_last_result
);

  // Sequencer and graph control state
  tos_pkg::state_t  state_r, state_nxt;
  tos_pkg::cnt_t    count_r, count_nxt;
  tos_pkg::status_t sticky_r, sticky_nxt;
  logic [tos_pkg::MAX_NODES-1:0] pred_valid_r, pred_valid_nxt;
  logic [tos_pkg::MAX_NODES-1:0] done_r, done_nxt;
  logic             q_vld_r, q_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working registers
  tos_pkg::key_t    cmp_key_r, cmp_key_nxt;
  tos_pkg::key_t    pkey_r, pkey_nxt;
  logic             has_r, has_nxt;
  tos_pkg::slot_t   dep_slot_r [tos_pkg::MAX_NODES];
  tos_pkg::slot_t   dep_slot_nxt [tos_pkg::MAX_NODES];
  tos_pkg::cnt_t    issue_r, issue_nxt;
  tos_pkg::slot_t   q_idx_r, q_idx_nxt;
  logic             hit_r, hit_nxt;
  tos_pkg::slot_t   hit_idx_r, hit_idx_nxt;
  logic             have_best_r, have_best_nxt;
  tos_pkg::key_t    best_key_r, best_key_nxt;
  tos_pkg::slot_t   best_slot_r, best_slot_nxt;
  tos_pkg::cnt_t    i_r, i_nxt;
  tos_pkg::cnt_t    step_r, step_nxt;
  tos_pkg::status_t res_status_r, res_status_nxt;
  tos_pkg::key_t    res_key_r, res_key_nxt;
  tos_pkg::slot_t   res_slot_r, res_slot_nxt;
  logic             res_last_r, res_last_nxt;
  tos_pkg::status_t out_status_r, out_status_nxt;
  tos_pkg::key_t    out_key_r, out_key_nxt;
  tos_pkg::slot_t   out_slot_r, out_slot_nxt;
  logic             out_last_r, out_last_nxt;

  tos_pkg::tbl_req_t tbl_req;
  tos_pkg::tbl_rsp_t tbl_rsp;

  logic in_acc;
  logic out_free;
  logic res_push;
  logic scan_state;
  logic issue_more;
  logic scan_done;
  logic cand;
  logic take;

  tos_node_table u_table (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  // Handshake
  assign in_stall = (state_r != tos_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign res_push = (state_r == tos_pkg::ST_REPORT) && out_free;

  // Scan engine: issue one slot a cycle, compare it the cycle after
  assign scan_state = (state_r == tos_pkg::ST_ADD_SCAN) ||
                      (state_r == tos_pkg::ST_RS_SCAN)  ||
                      (state_r == tos_pkg::ST_EM_SCAN);
  assign issue_more = (issue_r < count_r);
  assign scan_done  = !issue_more && !q_vld_r;

  // A node is ready when not yet emitted and its predecessor, if any, is done
  assign cand = q_vld_r && !done_r[q_idx_r] &&
                (!pred_valid_r[q_idx_r] || done_r[dep_slot_r[q_idx_r]]);
  assign take = cand && (!have_best_r || tbl_rsp.key_lt);

  // Node table requests
  always_comb begin
    tbl_req.wr_en        = 1'b0;
    tbl_req.wr_slot      = count_r[tos_pkg::SLOT_W-1:0];
    tbl_req.wr_key       = cmp_key_r;
    tbl_req.wr_pred      = has_r ? pkey_r : '0;
    tbl_req.key_rd_slot  = issue_r[tos_pkg::SLOT_W-1:0];
    tbl_req.pred_rd_slot = i_r[tos_pkg::SLOT_W-1:0];
    tbl_req.ref_key      = (state_r == tos_pkg::ST_EM_SCAN) ? best_key_r : cmp_key_r;
    if ((state_r == tos_pkg::ST_ADD_SCAN) && scan_done && !hit_r) begin
      tbl_req.wr_en = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tos_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == tos_pkg::OP_RUN) begin
            if ((sticky_r != tos_pkg::STAT_OK) || (count_r == '0)) begin
              state_nxt = tos_pkg::ST_REPORT;
            end else begin
              state_nxt = tos_pkg::ST_RS_NEXT;
            end
          end else if ((sticky_r == tos_pkg::STAT_OK) &&
                       (count_r != tos_pkg::cnt_t'(tos_pkg::MAX_NODES))) begin
            state_nxt = tos_pkg::ST_ADD_SCAN;
          end
        end
      end
      tos_pkg::ST_ADD_SCAN: begin
        if (scan_done) begin
          state_nxt = tos_pkg::ST_IDLE;
        end
      end
      tos_pkg::ST_RS_NEXT: begin
        if (i_r == count_r) begin
          state_nxt = tos_pkg::ST_EM_SCAN;
        end else if (pred_valid_r[i_r[tos_pkg::SLOT_W-1:0]]) begin
          state_nxt = tos_pkg::ST_RS_PKEY;
        end
      end
      tos_pkg::ST_RS_PKEY: begin
        state_nxt = tos_pkg::ST_RS_SCAN;
      end
      tos_pkg::ST_RS_SCAN: begin
        if (scan_done) begin
          state_nxt = hit_r ? tos_pkg::ST_RS_NEXT : tos_pkg::ST_REPORT;
        end
      end
      tos_pkg::ST_EM_SCAN: begin
        if (scan_done) begin
          state_nxt = tos_pkg::ST_REPORT;
        end
      end
      tos_pkg::ST_REPORT: begin
        if (out_free) begin
          state_nxt = res_last_r ? tos_pkg::ST_IDLE : tos_pkg::ST_EM_SCAN;
        end
      end
      default: begin
        state_nxt = tos_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    sticky_nxt     = sticky_r;
    pred_valid_nxt = pred_valid_r;
    done_nxt       = done_r;
    cmp_key_nxt    = cmp_key_r;
    pkey_nxt       = pkey_r;
    has_nxt        = has_r;
    dep_slot_nxt   = dep_slot_r;
    i_nxt          = i_r;
    step_nxt       = step_r;
    best_key_nxt   = best_key_r;
    best_slot_nxt  = best_slot_r;
    hit_idx_nxt    = hit_idx_r;
    q_idx_nxt      = q_idx_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_slot_nxt   = res_slot_r;
    res_last_nxt   = res_last_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;

    // Outside a scan, hold the scan engine at its start
    issue_nxt     = '0;
    q_vld_nxt     = 1'b0;
    hit_nxt       = 1'b0;
    have_best_nxt = 1'b0;

    if (scan_state) begin
      issue_nxt     = issue_r;
      hit_nxt       = hit_r;
      have_best_nxt = have_best_r;
      if (issue_more) begin
        q_vld_nxt = 1'b1;
        q_idx_nxt = issue_r[tos_pkg::SLOT_W-1:0];
        issue_nxt = issue_r + tos_pkg::cnt_t'(1);
      end
      if (q_vld_r && tbl_rsp.key_eq) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = q_idx_r;
      end
      if ((state_r == tos_pkg::ST_EM_SCAN) && take) begin
        have_best_nxt = 1'b1;
        best_key_nxt  = tbl_rsp.rd_key;
        best_slot_nxt = q_idx_r;
      end
    end

    case (state_r)
      tos_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmp_key_nxt = in_node_key[tos_pkg::KEY_BITS-1:0];
          pkey_nxt    = in_pred_key[tos_pkg::KEY_BITS-1:0];
          has_nxt     = in_has_pred;
          if (in_operation == tos_pkg::OP_RUN) begin
            i_nxt        = '0;
            step_nxt     = '0;
            done_nxt     = '0;
            res_key_nxt  = '0;
            res_slot_nxt = '0;
            res_last_nxt = 1'b1;
            res_status_nxt = (sticky_r != tos_pkg::STAT_OK) ? sticky_r
                                                            : tos_pkg::STAT_EMPTY;
          end else if ((sticky_r == tos_pkg::STAT_OK) &&
                       (count_r == tos_pkg::cnt_t'(tos_pkg::MAX_NODES))) begin
            sticky_nxt = tos_pkg::STAT_FULL;
          end
        end
      end
      tos_pkg::ST_ADD_SCAN: begin
        if (scan_done) begin
          if (hit_r) begin
            sticky_nxt = tos_pkg::STAT_DUP;
          end else begin
            pred_valid_nxt[count_r[tos_pkg::SLOT_W-1:0]] = has_r;
            count_nxt = count_r + tos_pkg::cnt_t'(1);
          end
        end
      end
      tos_pkg::ST_RS_NEXT: begin
        if ((i_r != count_r) && !pred_valid_r[i_r[tos_pkg::SLOT_W-1:0]]) begin
          i_nxt = i_r + tos_pkg::cnt_t'(1);
        end
      end
      tos_pkg::ST_RS_PKEY: begin
        cmp_key_nxt = tbl_rsp.rd_pred;
      end
      tos_pkg::ST_RS_SCAN: begin
        if (scan_done) begin
          if (hit_r) begin
            dep_slot_nxt[i_r[tos_pkg::SLOT_W-1:0]] = hit_idx_r;
            i_nxt = i_r + tos_pkg::cnt_t'(1);
          end else begin
            res_status_nxt = tos_pkg::STAT_UNKNOWN;
            res_key_nxt    = '0;
            res_slot_nxt   = '0;
            res_last_nxt   = 1'b1;
          end
        end
      end
      tos_pkg::ST_EM_SCAN: begin
        if (scan_done) begin
          if (have_best_r) begin
            done_nxt[best_slot_r] = 1'b1;
            res_status_nxt = tos_pkg::STAT_OK;
            res_key_nxt    = best_key_r;
            res_slot_nxt   = best_slot_r;
            res_last_nxt   = ((step_r + tos_pkg::cnt_t'(1)) == count_r);
            step_nxt       = step_r + tos_pkg::cnt_t'(1);
          end else begin
            res_status_nxt = tos_pkg::STAT_CYCLE;
            res_key_nxt    = '0;
            res_slot_nxt   = '0;
            res_last_nxt   = 1'b1;
          end
        end
      end
      tos_pkg::ST_REPORT: begin
        if (out_free) begin
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_slot_nxt   = res_slot_r;
          out_last_nxt   = res_last_r;
          // Drop the graph after the final result of a run
          if (res_last_r) begin
            count_nxt      = '0;
            sticky_nxt     = tos_pkg::STAT_OK;
            pred_valid_nxt = '0;
            done_nxt       = '0;
          end
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = res_push || (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tos_pkg::ST_IDLE;
      count_r      <= '0;
      sticky_r     <= tos_pkg::STAT_OK;
      pred_valid_r <= '0;
      done_r       <= '0;
      q_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      sticky_r     <= sticky_nxt;
      pred_valid_r <= pred_valid_nxt;
      done_r       <= done_nxt;
      q_vld_r      <= q_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_key_r    <= cmp_key_nxt;
    pkey_r       <= pkey_nxt;
    has_r        <= has_nxt;
    dep_slot_r   <= dep_slot_nxt;
    issue_r      <= issue_nxt;
    q_idx_r      <= q_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    have_best_r  <= have_best_nxt;
    best_key_r   <= best_key_nxt;
    best_slot_r  <= best_slot_nxt;
    i_r          <= i_nxt;
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_slot_r   <= res_slot_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_emitted_key  = tos_pkg::KEY_FIELD_W'(out_key_r);
  assign out_emitted_slot = tos_pkg::slot_field(out_slot_r);
  assign out_last_result  = out_last_r;

`ifndef ASSERT_OFF
  // The final result of a run leaves an empty graph behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_last_r |=> (count_r == '0) && (sticky_r == tos_pkg::STAT_OK) &&
                               (done_r == '0))
    else $error("graph not cleared after final result");

  // Error results always close the run
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tos_pkg::STAT_OK) |-> out_last_result)
    else $error("error result without last flag");

  // The chosen minimum was never emitted before
  a_best_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tos_pkg::ST_EM_SCAN) && scan_done && have_best_r |-> !done_r[best_slot_r])
    else $error("node emitted twice");

  // Node count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tos_pkg::cnt_t'(tos_pkg::MAX_NODES))
    else $error("node count beyond table size");
`endif

endmodule
